FILE: rtl/met_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package met_pkg;

  // Field and datapath widths.
  localparam int unsigned IN_W   = 57;   // input coordinate width
  localparam int unsigned Z_W    = 64;   // iterate width
  localparam int unsigned HALF_W = 32;   // multiplier operand width
  localparam int unsigned PROD_W = 128;  // full product width
  localparam int unsigned CNT_W  = 16;   // iteration counter width

  // Defaults and constants of the iteration.
  localparam int unsigned        FRAC_BITS_DEFAULT = 50;
  localparam logic [CNT_W-1:0]   LIMIT_RESET       = CNT_W'(1000);
  localparam logic [15:0]        ESCAPE_SQ         = 16'd2500;
  localparam logic [Z_W-1:0]     SAT_POS           = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [Z_W-1:0]     SAT_NEG           = 64'h8000_0000_0000_0001;

  // Sequencer states of the top level.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XX_GO,
    ST_XX_WAIT,
    ST_YY_GO,
    ST_YY_WAIT,
    ST_CHECK,
    ST_XY_GO,
    ST_XY_WAIT,
    ST_UPDATE
  } state_e;

  // Handshake between the sequencer and the shared product unit.
  typedef struct packed {
    logic start;
  } mul_req_t;

  typedef struct packed {
    logic done;
  } mul_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/mandelbrot_escape_time.sv
`timescale 1ns / 1ps
`default_nettype none

// Escape-time counter for one complex point c at a time. Raise start with
// c_real_i and c_imag_i (signed, FRAC_BITS fraction bits); the point is
// taken at a clock edge where start is high and busy is low, and busy stays
// high until the answer is out. The result appears on iteration_count_o and
// hit_limit_o for exactly one cycle, marked by result_valid_o; there is no
// way to hold it, so the receiver must take it in that cycle. All products
// go through one shared 32 x 32 multiplier, one 64-bit product at a time:
// x*x, y*y and, unless the point stops there, x*y in each iteration. A new
// point can be given in the strobe cycle. The iteration limit is written
// through the cfg port while the block is idle; it resets to 1000.
module mandelbrot_escape_time #(
  parameter int unsigned FRAC_BITS = met_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [met_pkg::IN_W-1:0]    c_real_i,
  input  wire logic [met_pkg::IN_W-1:0]    c_imag_i,
  output logic                             result_valid_o,
  output logic [met_pkg::CNT_W-1:0]        iteration_count_o,
  output logic                             hit_limit_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [met_pkg::CNT_W-1:0]   cfg_iteration_limit_i
);

  localparam int unsigned PW = met_pkg::PROD_W;
  localparam int unsigned ZW = met_pkg::Z_W;
  localparam int unsigned IW = met_pkg::IN_W;
  localparam logic [PW-1:0] EscapeThresh = PW'(met_pkg::ESCAPE_SQ) << (2 * FRAC_BITS);

  // Clamp a wide result into the signed 64-bit iterate.
  function automatic logic [ZW-1:0] sat_z(input logic [PW-1:0] v);
    logic same;
    same = (&v[PW-1:ZW-1]) || !(|v[PW-1:ZW-1]);
    if (same) begin
      return v[ZW-1:0];
    end
    return v[PW-1] ? met_pkg::SAT_NEG : met_pkg::SAT_POS;
  endfunction

  met_pkg::state_e            state_q, state_d;
  logic [ZW-1:0]              x_q, y_q;
  logic [IW-1:0]              cr_q, ci_q;
  logic [PW-1:0]              xx_q, yy_q, diff_q, xy_q;
  logic [met_pkg::CNT_W-1:0]  count_q, limit_q;
  logic                       valid_q, hit_q;

  met_pkg::mul_req_t          mul_req;
  met_pkg::mul_rsp_t          mul_rsp;
  logic [ZW-1:0]              mul_a, mul_b;
  logic [PW-1:0]              product;

  logic                       accept;
  logic                       escaped, at_limit, finish;
  logic [PW-1:0]              sum_sq;
  logic signed [PW-1:0]       re_w, im_w;

  // The limit is taken only while no point is in progress.
  assign busy        = (state_q != met_pkg::ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = !busy;

  // Shared product unit.
  met_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mul_req),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .rsp_o     (mul_rsp),
    .product_o (product)
  );

  // Operand selection: x*x, then y*y, then x*y.
  assign mul_a = (state_q == met_pkg::ST_YY_GO) ? y_q : x_q;
  assign mul_b = (state_q == met_pkg::ST_XX_GO) ? x_q : y_q;

  // Escape and limit tests on the squared magnitude.
  always_comb begin
    sum_sq   = xx_q + yy_q;
    escaped  = (sum_sq >= EscapeThresh);
    at_limit = (count_q >= limit_q);
  end

  // Next iterate, rounded toward minus infinity, plus c.
  always_comb begin
    re_w = ($signed(diff_q) >>> FRAC_BITS) + $signed({{(PW-IW){cr_q[IW-1]}}, cr_q});
    im_w = ($signed(xy_q) >>> (FRAC_BITS - 1)) + $signed({{(PW-IW){ci_q[IW-1]}}, ci_q});
  end

  // Sequencer: next state and strobes.
  always_comb begin
    state_d       = state_q;
    mul_req.start = 1'b0;
    finish        = 1'b0;
    unique case (state_q)
      met_pkg::ST_IDLE: begin
        if (start) begin
          state_d = met_pkg::ST_XX_GO;
        end
      end
      met_pkg::ST_XX_GO: begin
        mul_req.start = 1'b1;
        state_d       = met_pkg::ST_XX_WAIT;
      end
      met_pkg::ST_XX_WAIT: begin
        if (mul_rsp.done) begin
          state_d = met_pkg::ST_YY_GO;
        end
      end
      met_pkg::ST_YY_GO: begin
        mul_req.start = 1'b1;
        state_d       = met_pkg::ST_YY_WAIT;
      end
      met_pkg::ST_YY_WAIT: begin
        if (mul_rsp.done) begin
          state_d = met_pkg::ST_CHECK;
        end
      end
      met_pkg::ST_CHECK: begin
        if (escaped || at_limit) begin
          finish  = 1'b1;
          state_d = met_pkg::ST_IDLE;
        end else begin
          state_d = met_pkg::ST_XY_GO;
        end
      end
      met_pkg::ST_XY_GO: begin
        mul_req.start = 1'b1;
        state_d       = met_pkg::ST_XY_WAIT;
      end
      met_pkg::ST_XY_WAIT: begin
        if (mul_rsp.done) begin
          state_d = met_pkg::ST_UPDATE;
        end
      end
      met_pkg::ST_UPDATE: begin
        state_d = met_pkg::ST_XX_GO;
      end
      default: begin
        state_d = met_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= met_pkg::ST_IDLE;
      count_q <= '0;
      limit_q <= met_pkg::LIMIT_RESET;
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= finish;
      if (finish) begin
        hit_q <= !escaped;
      end
      if (accept) begin
        count_q <= '0;
      end else if (state_q == met_pkg::ST_UPDATE) begin
        count_q <= count_q + 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_iteration_limit_i;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cr_q <= c_real_i;
      ci_q <= c_imag_i;
      x_q  <= {{(ZW-IW){c_real_i[IW-1]}}, c_real_i};
      y_q  <= {{(ZW-IW){c_imag_i[IW-1]}}, c_imag_i};
    end else if (state_q == met_pkg::ST_UPDATE) begin
      x_q <= sat_z(re_w);
      y_q <= sat_z(im_w);
    end
    if ((state_q == met_pkg::ST_XX_WAIT) && mul_rsp.done) begin
      xx_q <= product;
    end
    if ((state_q == met_pkg::ST_YY_WAIT) && mul_rsp.done) begin
      yy_q <= product;
    end
    if ((state_q == met_pkg::ST_XY_WAIT) && mul_rsp.done) begin
      xy_q <= product;
    end
    if (state_q == met_pkg::ST_CHECK) begin
      diff_q <= xx_q - yy_q;
    end
  end

  assign result_valid_o    = valid_q;
  assign iteration_count_o = count_q;
  assign hit_limit_o       = hit_q;

endmodule

`default_nettype wire

FILE: rtl/met_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Signed 64 x 64 -> 128 product built from four 32 x 32 partial products.
// One partial product is formed per cycle and registered, then added into
// (or subtracted from) the accumulator in the following cycle.
module met_mul (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire met_pkg::mul_req_t             req_i,
  input  wire logic [met_pkg::Z_W-1:0]       a_i,
  input  wire logic [met_pkg::Z_W-1:0]       b_i,
  output met_pkg::mul_rsp_t                  rsp_o,
  output logic [met_pkg::PROD_W-1:0]         product_o
);

  logic [met_pkg::Z_W-1:0]              ma_q, mb_q;
  logic                                 neg_q;
  logic [1:0]                           step_q;
  logic                                 run_q;
  logic                                 pv_q, plast_q;
  logic [1:0]                           pshift_q;
  logic [2*met_pkg::HALF_W-1:0]         prod_q;
  logic [met_pkg::PROD_W-1:0]           acc_q, acc_d;
  logic                                 done_q;

  logic [met_pkg::Z_W-1:0]              ma_d, mb_d;
  logic [met_pkg::HALF_W-1:0]           a_half, b_half;
  logic [met_pkg::PROD_W-1:0]           term;

  // Operand magnitudes are taken once when a product starts.
  always_comb begin
    ma_d = a_i[met_pkg::Z_W-1] ? (~a_i + 1'b1) : a_i;
    mb_d = b_i[met_pkg::Z_W-1] ? (~b_i + 1'b1) : b_i;
  end

  // Step bit 1 picks the upper half of a, step bit 0 the upper half of b.
  always_comb begin
    a_half = step_q[1] ? ma_q[met_pkg::Z_W-1:met_pkg::HALF_W]
                       : ma_q[met_pkg::HALF_W-1:0];
    b_half = step_q[0] ? mb_q[met_pkg::Z_W-1:met_pkg::HALF_W]
                       : mb_q[met_pkg::HALF_W-1:0];
  end

  // The partial product is placed 0, 32 or 64 bits up and accumulated.
  always_comb begin
    term  = met_pkg::PROD_W'(prod_q) << {pshift_q, 5'd0};
    acc_d = neg_q ? (acc_q - term) : (acc_q + term);
  end

  // Operand and product registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ma_q  <= ma_d;
      mb_q  <= mb_d;
      neg_q <= a_i[met_pkg::Z_W-1] ^ b_i[met_pkg::Z_W-1];
    end
    if (run_q) begin
      prod_q   <= a_half * b_half;
      pshift_q <= 2'(step_q[1]) + 2'(step_q[0]);
    end
    if (req_i.start) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_d;
    end
  end

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      run_q   <= 1'b0;
      pv_q    <= 1'b0;
      plast_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      pv_q    <= run_q;
      plast_q <= run_q && (step_q == 2'd3);
      done_q  <= pv_q && plast_q;
      if (req_i.start) begin
        step_q <= '0;
        run_q  <= 1'b1;
      end else if (run_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign product_o  = acc_q;

endmodule

`default_nettype wire
